/* hw/rtl/c2p_pkg.sv */
`timescale 1ns / 1ps

package c2p_pkg;

  // Defaults for the top-level parameters.
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int PART_WIDTH_DEF    = 16;

  // Fixed formats of the datapath.
  localparam int ATAN_ENTRIES = 24;
  localparam int FRAC_BITS    = 16;
  localparam int Z_W          = 34;   // residual angle, Q2.30 with headroom
  localparam int MAG_W        = 16;
  localparam int ANG_W        = 16;
  localparam int GAIN_W       = 30;

  localparam logic signed [Z_W-1:0]   PI_Q30       = 34'sd3373259426;
  localparam logic signed [ANG_W-1:0] PI_Q13       = 16'sd25736;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q13  = 16'sd12868;
  localparam logic [GAIN_W-1:0]       INV_GAIN_Q30 = 30'd652032874;
  localparam logic [MAG_W-1:0]        MAG_MAX      = 16'hFFFF;

  // Values that ride along the pipeline next to the CORDIC vector.
  typedef struct packed {
    logic                    special;   // result is settled, CORDIC output ignored
    logic                    undef;
    logic [MAG_W-1:0]        mag;
    logic signed [ANG_W-1:0] ang;
  } side_t;

  // atan(2^-i) in Q2.30 radians.
  function automatic logic signed [Z_W-1:0] atan_q30(input int unsigned i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:       v = 34'sd843314857;
      1:       v = 34'sd497837829;
      2:       v = 34'sd263043837;
      3:       v = 34'sd133525159;
      4:       v = 34'sd67021687;
      5:       v = 34'sd33543516;
      6:       v = 34'sd16775851;
      7:       v = 34'sd8388437;
      8:       v = 34'sd4194283;
      9:       v = 34'sd2097149;
      10:      v = 34'sd1048576;
      11:      v = 34'sd524288;
      12:      v = 34'sd262144;
      13:      v = 34'sd131072;
      14:      v = 34'sd65536;
      15:      v = 34'sd32768;
      16:      v = 34'sd16384;
      17:      v = 34'sd8192;
      18:      v = 34'sd4096;
      19:      v = 34'sd2048;
      20:      v = 34'sd1024;
      21:      v = 34'sd512;
      22:      v = 34'sd256;
      default: v = 34'sd128;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/c2p_prep.sv */
`timescale 1ns / 1ps

module c2p_prep #(
  parameter int PW = c2p_pkg::PART_WIDTH_DEF,
  parameter int W  = PW + 19
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  logic signed [PW-1:0]  re,
  input  logic signed [PW-1:0]  im,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output logic signed [W-1:0]   x_o,
  output logic signed [W-1:0]   y_o,
  output logic signed [c2p_pkg::Z_W-1:0] z_o,
  output c2p_pkg::side_t        side_o
);
  import c2p_pkg::*;

  localparam int ABS_W = (PW + 1 > MAG_W + 1) ? PW + 1 : MAG_W + 1;

  logic                  valid_r;
  logic signed [W-1:0]   x_r, x_nxt, y_r, y_nxt;
  logic signed [Z_W-1:0] z_r, z_nxt;
  side_t                 side_r, side_nxt;

  logic signed [PW:0]    re_e, im_e;
  logic [PW:0]           abs_re, abs_im;
  logic [ABS_W-1:0]      ext_re, ext_im;
  logic [MAG_W-1:0]      sat_re, sat_im;
  logic signed [W-1:0]   xs, ys;
  logic                  re_zero, im_zero;

  always_comb begin
    re_e    = {re[PW-1], re};
    im_e    = {im[PW-1], im};
    abs_re  = re_e[PW] ? $unsigned(-re_e) : $unsigned(re_e);
    abs_im  = im_e[PW] ? $unsigned(-im_e) : $unsigned(im_e);
    ext_re  = ABS_W'(abs_re);
    ext_im  = ABS_W'(abs_im);
    sat_re  = (ext_re > ABS_W'(MAG_MAX)) ? MAG_MAX : ext_re[MAG_W-1:0];
    sat_im  = (ext_im > ABS_W'(MAG_MAX)) ? MAG_MAX : ext_im[MAG_W-1:0];
    re_zero = (re == '0);
    im_zero = (im == '0);

    // Scale both parts up to carry fractional bits through the iterations.
    xs = W'(re) <<< FRAC_BITS;
    ys = W'(im) <<< FRAC_BITS;

    side_nxt.special = re_zero || im_zero;
    side_nxt.undef   = re_zero && im_zero;
    side_nxt.mag     = '0;
    side_nxt.ang     = '0;
    if (re_zero && im_zero) begin
      side_nxt.mag = '0;
      side_nxt.ang = '0;
    end else if (im_zero) begin
      side_nxt.mag = sat_re;
      side_nxt.ang = re[PW-1] ? PI_Q13 : '0;
    end else if (re_zero) begin
      side_nxt.mag = sat_im;
      side_nxt.ang = im[PW-1] ? -HALF_PI_Q13 : HALF_PI_Q13;
    end

    // A vector in the left half plane is turned by pi first.
    if (re[PW-1]) begin
      x_nxt = -xs;
      y_nxt = -ys;
      z_nxt = im[PW-1] ? -PI_Q30 : PI_Q30;
    end else begin
      x_nxt = xs;
      y_nxt = ys;
      z_nxt = '0;
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      side_r <= side_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign x_o      = x_r;
  assign y_o      = y_r;
  assign z_o      = z_r;
  assign side_o   = side_r;

endmodule

/* hw/rtl/c2p_cell.sv */
`timescale 1ns / 1ps

module c2p_cell #(
  parameter int W     = c2p_pkg::PART_WIDTH_DEF + 19,
  parameter int SHIFT = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  logic signed [W-1:0]   x_i,
  input  logic signed [W-1:0]   y_i,
  input  logic signed [c2p_pkg::Z_W-1:0] z_i,
  input  c2p_pkg::side_t        side_i,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output logic signed [W-1:0]   x_o,
  output logic signed [W-1:0]   y_o,
  output logic signed [c2p_pkg::Z_W-1:0] z_o,
  output c2p_pkg::side_t        side_o
);
  import c2p_pkg::*;

  localparam logic signed [Z_W-1:0] ATAN_I = atan_q30(SHIFT);

  logic                  valid_r;
  logic signed [W-1:0]   x_r, x_nxt, y_r, y_nxt;
  logic signed [Z_W-1:0] z_r, z_nxt;
  side_t                 side_r;
  logic signed [W-1:0]   xsh, ysh;

  // One micro-rotation; the arithmetic shift rounds toward minus infinity.
  always_comb begin
    xsh = x_i >>> SHIFT;
    ysh = y_i >>> SHIFT;
    if (!y_i[W-1]) begin
      x_nxt = x_i + ysh;
      y_nxt = y_i - xsh;
      z_nxt = z_i + ATAN_I;
    end else begin
      x_nxt = x_i - ysh;
      y_nxt = y_i + xsh;
      z_nxt = z_i - ATAN_I;
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      side_r <= side_i;
    end
  end

  assign dn_valid = valid_r;
  assign x_o      = x_r;
  assign y_o      = y_r;
  assign z_o      = z_r;
  assign side_o   = side_r;

endmodule

/* hw/rtl/c2p_post.sv */
`timescale 1ns / 1ps

module c2p_post #(
  parameter int W = c2p_pkg::PART_WIDTH_DEF + 19
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  logic signed [W-1:0]   x_i,
  input  logic signed [c2p_pkg::Z_W-1:0] z_i,
  input  c2p_pkg::side_t        side_i,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output logic [c2p_pkg::MAG_W-1:0]        mag_o,
  output logic signed [c2p_pkg::ANG_W-1:0] ang_o,
  output logic                  undef_o
);
  import c2p_pkg::*;

  localparam int OVF_BIT = FRAC_BITS + 17;                  // 2^33 overflows the gain step
  localparam int XE_W    = (W > OVF_BIT + 1) ? W : OVF_BIT + 1;
  localparam int HI_W    = OVF_BIT - FRAC_BITS;             // upper slice of the gain product
  localparam int PH_W    = HI_W + GAIN_W;
  localparam int PL_W    = FRAC_BITS + GAIN_W;
  localparam int P_W     = 64;
  localparam int RSH     = FRAC_BITS + 30;
  localparam int ZR_W    = Z_W + 1;
  localparam int AR_W    = ZR_W - 17;

  // Stage A: clamp, overflow check, split gain product, angle rounding.
  logic                    a_valid_r;
  logic                    a_ready;
  logic                    b_ready;
  logic [PH_W-1:0]         a_ph_r, a_ph_nxt;
  logic [PL_W-1:0]         a_pl_r, a_pl_nxt;
  logic                    a_ovf_r, a_ovf_nxt;
  logic signed [ANG_W-1:0] a_ang_r, a_ang_nxt;
  side_t                   a_side_r;

  logic [XE_W-1:0]         xe;
  logic signed [ZR_W-1:0]  zr;
  logic signed [AR_W-1:0]  ar;

  always_comb begin
    xe        = x_i[W-1] ? '0 : XE_W'($unsigned(x_i));
    a_ovf_nxt = |xe[XE_W-1:OVF_BIT];
    a_ph_nxt  = PH_W'(xe[OVF_BIT-1:FRAC_BITS]) * PH_W'(INV_GAIN_Q30);
    a_pl_nxt  = PL_W'(xe[FRAC_BITS-1:0]) * PL_W'(INV_GAIN_Q30);

    // Q2.30 to Q2.13, round to nearest with ties up, then clamp to pi.
    zr = ZR_W'(z_i) + ZR_W'(65536);
    ar = zr[ZR_W-1:17];
    if (ar > AR_W'(PI_Q13)) begin
      a_ang_nxt = PI_Q13;
    end else if (ar < -AR_W'(PI_Q13)) begin
      a_ang_nxt = -PI_Q13;
    end else begin
      a_ang_nxt = ar[ANG_W-1:0];
    end
    if (side_i.special) begin
      a_ang_nxt = side_i.ang;
    end
  end

  assign a_ready  = !a_valid_r || b_ready;
  assign up_ready = a_ready;

  // Stage B: sum the partial products, round, saturate.
  logic                    b_valid_r;
  logic [MAG_W-1:0]        b_mag_r, b_mag_nxt;
  logic signed [ANG_W-1:0] b_ang_r;
  logic                    b_undef_r;
  logic [P_W-1:0]          p;
  logic [P_W-RSH-1:0]      pr;

  always_comb begin
    p  = (P_W'(a_ph_r) << FRAC_BITS) + P_W'(a_pl_r) + (P_W'(1) << (RSH - 1));
    pr = p[P_W-1:RSH];
    if (a_side_r.special) begin
      b_mag_nxt = a_side_r.mag;
    end else if (a_ovf_r || (pr > (P_W-RSH)'(MAG_MAX))) begin
      b_mag_nxt = MAG_MAX;
    end else begin
      b_mag_nxt = pr[MAG_W-1:0];
    end
  end

  assign b_ready = !b_valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= up_valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && up_valid) begin
      a_ph_r   <= a_ph_nxt;
      a_pl_r   <= a_pl_nxt;
      a_ovf_r  <= a_ovf_nxt;
      a_ang_r  <= a_ang_nxt;
      a_side_r <= side_i;
    end
    if (b_ready && a_valid_r) begin
      b_mag_r   <= b_mag_nxt;
      b_ang_r   <= a_ang_r;
      b_undef_r <= a_side_r.undef;
    end
  end

  assign dn_valid = b_valid_r;
  assign mag_o    = b_mag_r;
  assign ang_o    = b_ang_r;
  assign undef_o  = b_undef_r;

endmodule

/* hw/rtl/cartesian_to_polar_core.sv */
`timescale 1ns / 1ps
// Path: input stage, one registered cell per CORDIC stage, then output stages A and B.
// Throughput: one vector per cycle while out_tready is high; a stage refills as soon
// as its contents move on, so bubbles close up under stalls.
// Reset: synchronous, active-low rst_n clears every stage's valid flag; the datapath
// registers are not reset.
module cartesian_to_polar_core #(
  parameter int CORDIC_STAGES = c2p_pkg::CORDIC_STAGES_DEF,
  parameter int PART_WIDTH    = c2p_pkg::PART_WIDTH_DEF,
  parameter int IN_DATA_W     = ((2 * PART_WIDTH + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input channel.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_DATA_W-1:0]   in_tdata,   // real_part, imag_part (PART_WIDTH each), zero pad
  // Result channel.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [31:0]            out_tdata,  // magnitude [15:0], angle [31:16]
  output logic                   out_tuser   // angle_undefined
);
  import c2p_pkg::*;

  // Working width of the vector: part width, fractional bits, and growth from
  // the CORDIC gain plus the sign.
  localparam int W = PART_WIDTH + FRAC_BITS + 3;
  // The angle table ends after its last entry, so the chain never grows past it.
  localparam int N = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

  logic signed [PART_WIDTH-1:0] re, im;
  assign re = in_tdata[PART_WIDTH-1:0];
  assign im = in_tdata[2*PART_WIDTH-1:PART_WIDTH];

  // Chain links: index k feeds cell k, index N feeds the output stage.
  logic                  lv   [0:N];
  logic                  lr   [0:N];
  logic signed [W-1:0]   lx   [0:N];
  logic signed [W-1:0]   ly   [0:N];
  logic signed [Z_W-1:0] lz   [0:N];
  side_t                 ls   [0:N];

  // Input stage: special cases and the left half plane turn.
  c2p_prep #(
    .PW (PART_WIDTH),
    .W  (W)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .re       (re),
    .im       (im),
    .dn_valid (lv[0]),
    .dn_ready (lr[0]),
    .x_o      (lx[0]),
    .y_o      (ly[0]),
    .z_o      (lz[0]),
    .side_o   (ls[0])
  );

  // Row of micro-rotation cells, cell k shifting by k.
  for (genvar k = 0; k < N; k++) begin : g_cell
    c2p_cell #(
      .W     (W),
      .SHIFT (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (lv[k]),
      .up_ready (lr[k]),
      .x_i      (lx[k]),
      .y_i      (ly[k]),
      .z_i      (lz[k]),
      .side_i   (ls[k]),
      .dn_valid (lv[k+1]),
      .dn_ready (lr[k+1]),
      .x_o      (lx[k+1]),
      .y_o      (ly[k+1]),
      .z_o      (lz[k+1]),
      .side_o   (ls[k+1])
    );
  end

  // Gain removal, angle rounding and the output register. The final y value
  // is not needed past the last cell.
  logic [MAG_W-1:0]        mag;
  logic signed [ANG_W-1:0] ang;

  c2p_post #(
    .W (W)
  ) u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (lv[N]),
    .up_ready (lr[N]),
    .x_i      (lx[N]),
    .z_i      (lz[N]),
    .side_i   (ls[N]),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .mag_o    (mag),
    .ang_o    (ang),
    .undef_o  (out_tuser)
  );

  assign out_tdata = {ang, mag};

endmodule
